// ----- rtl/core/hsl2rgb_pkg.sv -----
// Shared types and constants for the HSL to RGB converter.
// No dependencies; imported by hsl2rgb_chan and hsl_to_rgb_clamped_unit.
package hsl2rgb_pkg;

  // field widths fixed by the stream format
  localparam int HUE_W  = 9;
  localparam int CODE_W = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // pipeline depth, one valid bit per stage
  localparam int NUM_STAGES = 6;

  // hue scaling: hue_fx = (hue_degrees * HUE_M) >> HUE_SHIFT, exact for 9-bit input
  localparam int HUE_SHIFT = 18;

  // configuration register indexes
  localparam logic CFG_CHANNEL_MIN = 1'b0;
  localparam logic CFG_CHANNEL_MAX = 1'b1;

  // piece of the hue curve a channel falls in
  typedef enum logic [3:0] {
    RG_RISE = 4'b0001,
    RG_FLAT = 4'b0010,
    RG_FALL = 4'b0100,
    RG_LOW  = 4'b1000
  } region_t;

  // per-stage load enables handed to each channel slice
  typedef struct packed {
    logic op_en;   // stage 3: region and multiplier operand
    logic mul_en;  // stage 4: span product
    logic sel_en;  // stage 5: level to 8-bit channel
    logic lim_en;  // stage 6: min/max limit
  } chan_ctl_t;

endpackage

// ----- rtl/core/hsl2rgb_chan.sv -----
// One color channel slice: hue piece select, span multiply, scale and limit.
// Depends on hsl2rgb_pkg; instantiated three times by hsl_to_rgb_clamped_unit.
module hsl2rgb_chan
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  chan_ctl_t             ctl,
  input  logic [FRAC_BITS-1:0]  t_i,       // stage 2: wrapped hue for this channel
  input  logic [FRAC_BITS+1:0]  span_i,    // stage 3: v2 - v1
  input  logic [FRAC_BITS+1:0]  v1_i,      // stage 4: low level
  input  logic                  grey_i,    // stage 4: zero saturation
  input  logic [CODE_W-1:0]     lig_i,     // stage 4: lightness code
  input  logic [CODE_W-1:0]     ch_min_i,
  input  logic [CODE_W-1:0]     ch_max_i,
  output logic [CODE_W-1:0]     chan_o     // stage 6
);

  localparam int F = FRAC_BITS;
  localparam logic [F+2:0] ONE_W3   = {3'b001, {F{1'b0}}};
  localparam logic [F:0]   ONE_W1   = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] TWO_W2   = {2'b10, {F{1'b0}}};
  localparam logic [F-1:0] TWO_THIRDS_FX = F'((64'd2 << F) / 64'd3);

  // stage 3: region and operand
  logic [F+2:0] six_t, six_d, t_w3;
  logic [F+1:0] three_t;
  logic [F:0]   two_t;
  logic [F-1:0] d_fall;
  region_t      rg_nxt, rg3_r;
  logic [F-1:0] op_nxt, op3_r;

  always_comb begin
    t_w3    = (F+3)'(t_i);
    six_t   = (t_w3 << 2) + (t_w3 << 1);
    two_t   = {t_i, 1'b0};
    three_t = (F+2)'({t_i, 1'b0}) + (F+2)'(t_i);
    d_fall  = TWO_THIRDS_FX - t_i;
    six_d   = ((F+3)'(d_fall) << 2) + ((F+3)'(d_fall) << 1);
    if (six_t < ONE_W3) begin
      rg_nxt = RG_RISE;
      op_nxt = six_t[F-1:0];
    end else if (two_t < ONE_W1) begin
      rg_nxt = RG_FLAT;
      op_nxt = '0;
    end else if (three_t < TWO_W2) begin
      rg_nxt = RG_FALL;
      op_nxt = six_d[F-1:0];   // below ONE within this piece
    end else begin
      rg_nxt = RG_LOW;
      op_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op_en) begin
      rg3_r <= rg_nxt;
      op3_r <= op_nxt;
    end
  end

  // stage 4: span * operand, keep the integer part above F fraction bits
  logic [2*F+1:0] prod;
  logic [F+1:0]   add_nxt, add4_r;

  assign prod = (2*F+2)'(span_i) * (2*F+2)'(op3_r);

  always_comb begin
    unique case (rg3_r) inside
      RG_RISE, RG_FALL: add_nxt = prod[2*F+1:F];
      RG_FLAT:          add_nxt = span_i;
      RG_LOW:           add_nxt = '0;
      default:          add_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      add4_r <= add_nxt;
    end
  end

  // stage 5: level -> floor(255*v / ONE), capped at 255; grey bypass
  logic [F+2:0]  lvl;
  logic [F+10:0] scaled;
  logic [10:0]   cval;
  logic [CODE_W-1:0] ch_nxt, ch5_r;

  always_comb begin
    lvl    = (F+3)'(v1_i) + (F+3)'(add4_r);
    scaled = {lvl, 8'b0} - (F+11)'(lvl);
    cval   = scaled[F+10:F];
    if (grey_i) begin
      ch_nxt = lig_i;
    end else if (|cval[10:8]) begin
      ch_nxt = 8'hFF;
    end else begin
      ch_nxt = cval[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sel_en) begin
      ch5_r <= ch_nxt;
    end
  end

  // stage 6: limit; if min > max, below-min values get min, others get max
  logic [CODE_W-1:0] lim_nxt;

  always_comb begin
    if (ch5_r < ch_min_i) begin
      lim_nxt = ch_min_i;
    end else if (ch5_r > ch_max_i) begin
      lim_nxt = ch_max_i;
    end else begin
      lim_nxt = ch5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lim_en) begin
      chan_o <= lim_nxt;
    end
  end

endmodule

// ----- rtl/core/hsl_to_rgb_clamped_unit.sv -----
// Top level of the HSL to RGB converter with per-channel min/max limiting.
// Depends on hsl2rgb_pkg and hsl2rgb_chan.

// Converts one HSL color per clock into 8-bit red, green and blue. The block is a
// six-stage pipeline: (1) code-to-fraction lookup and hue scaling multiply,
// (2) l*s product and hue-third wrap, (3) blend levels v1/v2 and the piece of the
// hue curve per channel, (4) one span multiply per channel, (5) scale to 8 bits
// with the grey bypass for zero saturation, (6) the channel_min/channel_max limit.
// A new color can be transferred every cycle unless the result side stalls. The
// per-channel span multiplier in stage 4 and the l*s multiplier in stage 2 set the
// stage depth. Each stage has a valid bit and loads whenever it is empty or the
// stage after it moves, so back-pressure on the result side holds every item in
// place and bubbles are squeezed out. Hue values of 360 and above wrap as if 360
// were subtracted. Config writes are always accepted (cfg_ready is tied high);
// write them only while no item is in flight.
module hsl_to_rgb_clamped_unit
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input color stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [8:0] hue_degrees, [16:9] saturation,
                                             // [24:17] lightness, [31:25] zero
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  // config writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CODE_W-1:0]      cfg_data
);

  localparam int F = FRAC_BITS;
  localparam logic [F:0]   ONE_FX   = {1'b1, {F{1'b0}}};
  localparam logic [F:0]   HALF_FX  = {2'b01, {(F-1){1'b0}}};
  localparam logic [F-1:0] THIRD_FX = F'((64'd1 << F) / 64'd3);
  localparam logic [F-1:0] NTHIRD_FX = F'((64'd1 << F) - ((64'd1 << F) / 64'd3));
  localparam logic [63:0]  HUE_M_FULL =
    ((64'd1 << (F + HUE_SHIFT)) + 64'd359) / 64'd360;
  localparam logic [F+9:0] HUE_M = HUE_M_FULL[F+9:0];

  // ---------------------------------------------------------------- config
  logic [CODE_W-1:0] ch_min_r, ch_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_min_r <= '0;
      ch_max_r <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHANNEL_MIN: ch_min_r <= cfg_data;
        CFG_CHANNEL_MAX: ch_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [NUM_STAGES-1:0] vld_r, en;
  chan_ctl_t             ctl;

  // a stage loads when empty or when the next one moves
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NUM_STAGES-1];

  assign ctl.op_en  = en[2];
  assign ctl.mul_en = en[3];
  assign ctl.sel_en = en[4];
  assign ctl.lim_en = en[5];

  // ---------------------------------------------------------------- stage 1
  logic [HUE_W-1:0]  in_hue;
  logic [CODE_W-1:0] in_sat, in_lig;

  assign in_hue = in_tdata[HUE_W-1:0];
  assign in_sat = in_tdata[HUE_W+CODE_W-1:HUE_W];
  assign in_lig = in_tdata[HUE_W+2*CODE_W-1:HUE_W+CODE_W];

  // code -> ceil(code * ONE / 255), so grey comes back exactly as the code
  logic [F:0] code_fx [256];
  for (genvar i = 0; i < 256; i++) begin : g_code_tab
    assign code_fx[i] = (F+1)'(((64'(i) << F) + 64'd254) / 64'd255);
  end

  // floor(hue * ONE / 360) by reciprocal multiply, exact over 9 bits
  logic [F+18:0] hue_prod;
  assign hue_prod = (F+19)'(in_hue) * (F+19)'(HUE_M);

  logic              sz1_r;
  logic [CODE_W-1:0] lig1_r;
  logic [F:0]        s1_r, l1_r, hue1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sz1_r  <= (in_sat == '0);
      lig1_r <= in_lig;
      s1_r   <= code_fx[in_sat];
      l1_r   <= code_fx[in_lig];
      hue1_r <= hue_prod[F+HUE_SHIFT:HUE_SHIFT];
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [2*F+1:0]    ls_prod;
  logic              sz2_r;
  logic [CODE_W-1:0] lig2_r;
  logic [F:0]        s2_r, l2_r, p2_r;
  logic [F-1:0]      tr2_r, tg2_r, tb2_r;
  logic [F:0]        hue_r_sum, hue_b_sum;

  assign ls_prod   = (2*F+2)'(l1_r) * (2*F+2)'(s1_r);
  assign hue_r_sum = hue1_r + (F+1)'(THIRD_FX);
  assign hue_b_sum = hue1_r + (F+1)'(NTHIRD_FX);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sz2_r  <= sz1_r;
      lig2_r <= lig1_r;
      s2_r   <= s1_r;
      l2_r   <= l1_r;
      p2_r   <= ls_prod[2*F:F];      // l*s <= ONE*ONE
      tr2_r  <= hue_r_sum[F-1:0];    // wrap into [0,1)
      tg2_r  <= hue1_r[F-1:0];
      tb2_r  <= hue_b_sum[F-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [F+2:0] l_w, two_l, v2_nxt, v1_nxt, v2m_nxt;
  logic         sz3_r;
  logic [CODE_W-1:0] lig3_r;
  logic [F+1:0] v1_3_r, span3_r;

  always_comb begin
    l_w   = (F+3)'(l2_r);
    two_l = l_w << 1;
    if (l2_r < HALF_FX) begin
      v2_nxt = l_w + (F+3)'(p2_r);
    end else begin
      v2_nxt = l_w + (F+3)'(s2_r) - (F+3)'(p2_r);
    end
    v1_nxt  = (two_l > v2_nxt) ? (two_l - v2_nxt) : '0;
    v2m_nxt = (v2_nxt < v1_nxt) ? v1_nxt : v2_nxt;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sz3_r   <= sz2_r;
      lig3_r  <= lig2_r;
      v1_3_r  <= v1_nxt[F+1:0];
      span3_r <= (F+2)'(v2m_nxt - v1_nxt);
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic              sz4_r;
  logic [CODE_W-1:0] lig4_r;
  logic [F+1:0]      v1_4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sz4_r  <= sz3_r;
      lig4_r <= lig3_r;
      v1_4_r <= v1_3_r;
    end
  end

  // ---------------------------------------------------------------- channels
  logic [CODE_W-1:0] red, green, blue;

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk(clk), .ctl(ctl), .t_i(tr2_r), .span_i(span3_r), .v1_i(v1_4_r),
    .grey_i(sz4_r), .lig_i(lig4_r), .ch_min_i(ch_min_r), .ch_max_i(ch_max_r),
    .chan_o(red)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk(clk), .ctl(ctl), .t_i(tg2_r), .span_i(span3_r), .v1_i(v1_4_r),
    .grey_i(sz4_r), .lig_i(lig4_r), .ch_min_i(ch_min_r), .ch_max_i(ch_max_r),
    .chan_o(green)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk(clk), .ctl(ctl), .t_i(tb2_r), .span_i(span3_r), .v1_i(v1_4_r),
    .grey_i(sz4_r), .lig_i(lig4_r), .ch_min_i(ch_min_r), .ch_max_i(ch_max_r),
    .chan_o(blue)
  );

  assign out_tdata = {blue, green, red};

  // ---------------------------------------------------------------- checks
  // an empty output stage must never block the input side
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with output stage empty");

  // every input transfer occupies stage 1 on the next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item lost at stage 1");

  // blend levels stay within [0, 1]
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> ((F+3)'(v1_3_r) + (F+3)'(span3_r)) <= (F+3)'(ONE_FX))
    else $error("blend level above one");

endmodule
